[rtl/core/integer_to_ascii_radix_core_defines.svh]
// Assertion helpers shared by the core modules. Every module that uses them
// has a clock named clk and a synchronous active-high reset named rst.
`ifndef INTEGER_TO_ASCII_RADIX_CORE_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ITAR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ITAR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/itar_pkg.sv]
package itar_pkg;

  localparam int VALUE_W       = 32;
  localparam int CHAR_W        = 7;
  localparam int RADIX_W       = 6;
  localparam int APB_DATA_W    = 32;
  localparam int APB_ADDR_W    = 2;

  localparam int MAX_CHARS     = 32;
  localparam int RESULT_CAP    = 32;
  localparam int CHAR_CAP      = (MAX_CHARS < RESULT_CAP) ? MAX_CHARS : RESULT_CAP;
  localparam int IDX_W         = $clog2(CHAR_CAP);
  localparam int CNT_W         = $clog2(CHAR_CAP + 1);

  // The divider retires this many quotient bits per cycle.
  localparam int BITS_PER_STEP = 8;
  localparam int DIV_STEPS     = VALUE_W / BITS_PER_STEP;
  localparam int STEP_W        = $clog2(DIV_STEPS);

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;

  localparam logic [APB_ADDR_W-1:0] ADDR_RADIX = 2'd0;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
  localparam logic [CHAR_W-1:0] TEN        = 7'd10;

  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] dividend;
    logic [RADIX_W-1:0] divisor;
  } div_ctrl_t;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quotient;
    logic [RADIX_W-1:0] remainder;
  } div_stat_t;

  typedef struct packed {
    logic              clear;
    logic              wr_en;
    logic [CHAR_W-1:0] wr_char;
    logic              emit_start;
  } buf_ctrl_t;

  typedef struct packed {
    logic busy;
  } buf_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] rem);
    logic [CHAR_W-1:0] r;
    r = {1'b0, rem};
    if (r > 7'd9) begin
      digit_char = r - TEN + CHAR_A;
    end else begin
      digit_char = r + CHAR_ZERO;
    end
  endfunction

endpackage

[rtl/core/itar_if.sv]
interface itar_value_if;
  logic                                valid;
  logic                                ready;
  logic signed [itar_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itar_char_if;
  logic                         valid;
  logic                         ready;
  logic [itar_pkg::CHAR_W-1:0]  char_code;
  logic                         last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

[rtl/core/itar_divider.sv]
`include "integer_to_ascii_radix_core_defines.svh"

module itar_divider (
  input  logic                clk,
  input  logic                rst,
  input  itar_pkg::div_ctrl_t ctrl,
  output itar_pkg::div_stat_t stat
);

  logic                          busy;
  logic                          done;
  logic [itar_pkg::STEP_W-1:0]   step;
  logic [itar_pkg::VALUE_W-1:0]  work;
  logic [itar_pkg::RADIX_W-1:0]  rem;
  logic [itar_pkg::RADIX_W-1:0]  divisor;
  logic [itar_pkg::VALUE_W-1:0]  work_next;
  logic [itar_pkg::RADIX_W-1:0]  rem_next;

  // Restoring division, several bits per cycle. The dividend shifts out of
  // the top of work while quotient bits shift in at the bottom.
  always_comb begin
    logic [itar_pkg::RADIX_W:0] trial;
    work_next = work;
    rem_next  = rem;
    for (int i = 0; i < itar_pkg::BITS_PER_STEP; i++) begin
      trial     = {rem_next, work_next[itar_pkg::VALUE_W-1]};
      work_next = {work_next[itar_pkg::VALUE_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        trial        = trial - {1'b0, divisor};
        work_next[0] = 1'b1;
      end
      rem_next = trial[itar_pkg::RADIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (ctrl.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == itar_pkg::STEP_W'(itar_pkg::DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work <= '0;
    end else if (ctrl.start) begin
      work <= ctrl.dividend;
    end else if (busy) begin
      work <= work_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem     <= '0;
      divisor <= ctrl.divisor;
    end else if (busy) begin
      rem <= rem_next;
    end
  end

  assign stat.done      = done;
  assign stat.quotient  = work;
  assign stat.remainder = rem;

  `ITAR_ASSERT_SAME(a_div_start_idle, ctrl.start, !busy, "divider restarted while busy")

endmodule

[rtl/core/itar_char_buf.sv]
`include "integer_to_ascii_radix_core_defines.svh"

module itar_char_buf (
  input  logic                clk,
  input  logic                rst,
  input  itar_pkg::buf_ctrl_t ctrl,
  output itar_pkg::buf_stat_t stat,
  itar_char_if.source         text
);

  logic [itar_pkg::CHAR_W-1:0] store [itar_pkg::CHAR_CAP];
  logic [itar_pkg::CNT_W-1:0]  count;
  logic [itar_pkg::CNT_W-1:0]  ptr;
  logic [itar_pkg::CNT_W-1:0]  ptr_dec;
  logic                        emitting;
  logic                        out_valid;
  logic [itar_pkg::CHAR_W-1:0] out_char;
  logic                        out_last;
  logic                        load;
  logic                        can_write;

  assign can_write = ctrl.wr_en && (count < itar_pkg::CNT_W'(itar_pkg::CHAR_CAP));
  assign ptr_dec   = ptr - 1'b1;
  // The output register reloads when empty or when its beat is taken.
  assign load      = emitting && (!out_valid || text.ready);

  always_ff @(posedge clk) begin
    if (can_write) begin
      store[count[itar_pkg::IDX_W-1:0]] <= ctrl.wr_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.clear) begin
      count <= '0;
    end else if (can_write) begin
      count <= count + 1'b1;
    end
  end

  // Characters were stored least significant first, so they are read back
  // from the top of the store down.
  always_ff @(posedge clk) begin
    if (rst) begin
      emitting <= 1'b0;
      ptr      <= '0;
    end else if (ctrl.emit_start) begin
      emitting <= 1'b1;
      ptr      <= count;
    end else if (load) begin
      ptr <= ptr_dec;
      if (ptr_dec == '0) begin
        emitting <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (text.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= store[ptr_dec[itar_pkg::IDX_W-1:0]];
      out_last <= (ptr_dec == '0);
    end
  end

  assign text.valid     = out_valid;
  assign text.char_code = out_char;
  assign text.last_char = out_last;
  assign stat.busy      = emitting;

  `ITAR_ASSERT_SAME(a_buf_no_write_emit, ctrl.wr_en || ctrl.clear, !emitting,
                    "character store written during readout")
  `ITAR_ASSERT_SAME(a_buf_emit_nonempty, ctrl.emit_start, count != '0,
                    "readout started on an empty store")

endmodule

[rtl/core/integer_to_ascii_radix_core.sv]
// Integer to text converter in a configurable base.
// The number channel takes one signed 32-bit value per beat. The text
// channel returns its characters most significant first, one per beat,
// with last_char set on the final one. Base 10 negative values get a
// leading '-'; other bases read the value as unsigned. Digits above 9 are
// lower-case letters, and zero gives a single '0'.
// The radix register sits at APB byte address 0; the base in use is its
// value saturated to 2..36. A single shared divider produces the digits
// one at a time, least significant first, each by a full division of the
// previous quotient, 8 quotient bits at a time. Once the quotient reaches
// zero, a '-' is stored for a negative value and readout begins;
// characters then leave at one per cycle while the receiver is ready.
// The number channel is ready only between items. If the receiver stalls,
// readout holds in the output register and the block waits.
// Reset sets the radix to 10 and leaves the block idle with no text pending.
`include "integer_to_ascii_radix_core_defines.svh"

module integer_to_ascii_radix_core (
  input  logic                              clk,
  input  logic                              rst,
  itar_value_if.sink                        number,
  itar_char_if.source                       text,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [itar_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [itar_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [itar_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DIVIDE = 5'b00010,
    ST_SIGN   = 5'b00100,
    ST_START  = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t                        state;
  state_t                        state_next;
  logic [itar_pkg::RADIX_W-1:0]  radix;
  logic [itar_pkg::RADIX_W-1:0]  base;
  logic                          negative;
  logic                          accept;
  logic                          in_negative;
  logic [itar_pkg::VALUE_W-1:0]  pattern;
  itar_pkg::div_ctrl_t           div_ctrl;
  itar_pkg::div_stat_t           div_stat;
  itar_pkg::buf_ctrl_t           buf_ctrl;
  itar_pkg::buf_stat_t           buf_stat;

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= itar_pkg::RADIX_RESET;
    end else if (psel && penable && pwrite && (paddr == itar_pkg::ADDR_RADIX)) begin
      radix <= pwdata[itar_pkg::RADIX_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == itar_pkg::ADDR_RADIX) begin
      prdata = itar_pkg::APB_DATA_W'(radix);
    end
  end

  // Base saturation and sign handling for the incoming value.
  always_comb begin
    if (radix < itar_pkg::RADIX_MIN) begin
      base = itar_pkg::RADIX_MIN;
    end else if (radix > itar_pkg::RADIX_MAX) begin
      base = itar_pkg::RADIX_MAX;
    end else begin
      base = radix;
    end
  end

  assign accept      = number.valid && number.ready;
  assign in_negative = (base == itar_pkg::RADIX_DEC) && number.value[itar_pkg::VALUE_W-1];
  assign pattern     = in_negative ? (~number.value + 1'b1) : number.value;

  assign number.ready = (state == ST_IDLE);

  // Sequencer.
  always_comb begin
    state_next        = state;
    div_ctrl.start    = 1'b0;
    div_ctrl.dividend = div_stat.quotient;
    div_ctrl.divisor  = base;
    buf_ctrl.clear      = 1'b0;
    buf_ctrl.wr_en      = 1'b0;
    buf_ctrl.wr_char    = itar_pkg::digit_char(div_stat.remainder);
    buf_ctrl.emit_start = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          div_ctrl.start    = 1'b1;
          div_ctrl.dividend = pattern;
          buf_ctrl.clear    = 1'b1;
          state_next        = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_stat.done) begin
          buf_ctrl.wr_en = 1'b1;
          if (div_stat.quotient != '0) begin
            div_ctrl.start = 1'b1;
          end else if (negative) begin
            state_next = ST_SIGN;
          end else begin
            state_next = ST_START;
          end
        end
      end
      ST_SIGN: begin
        buf_ctrl.wr_en   = 1'b1;
        buf_ctrl.wr_char = itar_pkg::CHAR_MINUS;
        state_next       = ST_START;
      end
      ST_START: begin
        buf_ctrl.emit_start = 1'b1;
        state_next          = ST_EMIT;
      end
      ST_EMIT: begin
        if (!buf_stat.busy) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      negative <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        negative <= in_negative;
      end
    end
  end

  itar_divider u_divider (
    .clk  (clk),
    .rst  (rst),
    .ctrl (div_ctrl),
    .stat (div_stat)
  );

  itar_char_buf u_char_buf (
    .clk  (clk),
    .rst  (rst),
    .ctrl (buf_ctrl),
    .stat (buf_stat),
    .text (text)
  );

  `ITAR_ASSERT_NEXT(a_busy_after_accept, accept, !number.ready,
                    "number channel ready right after an accepted beat")
  `ITAR_ASSERT_SAME(a_done_in_divide, div_stat.done, state == ST_DIVIDE,
                    "divider finished outside the divide phase")

endmodule
